[hw/rtl/pcm_bytes_to_mono_fixed_macros.svh]
// ----------------------------------------------------------------------------
// PCM bytes to mono fixed: assertion macros
// Concurrent assertion shorthands, empty when synthesizing.
// ----------------------------------------------------------------------------
`ifndef PCM_BYTES_TO_MONO_FIXED_MACROS_SVH
`define PCM_BYTES_TO_MONO_FIXED_MACROS_SVH

`ifndef SYNTHESIS
`define PBMF_ASSERT_NOW(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("pbmf assertion failed");
`define PBMF_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("pbmf assertion failed");
`else
`define PBMF_ASSERT_NOW(label, clk, rstn, ante, cons)
`define PBMF_ASSERT_NEXT(label, clk, rstn, ante, cons)
`endif

`endif

[hw/rtl/pbmf_pkg.sv]
// ----------------------------------------------------------------------------
// PCM bytes to mono fixed: package
// Shared types and codes of the converter.
// ----------------------------------------------------------------------------
`default_nettype none

package pbmf_pkg;

    localparam logic [2:0] FMT_U8  = 3'd0;
    localparam logic [2:0] FMT_S16 = 3'd1;
    localparam logic [2:0] FMT_S24 = 3'd2;
    localparam logic [2:0] FMT_S32 = 3'd3;
    localparam logic [2:0] FMT_F32 = 3'd4;

    localparam logic [1:0] REG_FORMAT     = 2'd0;
    localparam logic [1:0] REG_BIG_ENDIAN = 2'd1;
    localparam logic [1:0] REG_CHANNELS   = 2'd2;
    localparam logic [1:0] REG_FRAMES     = 2'd3;

    typedef enum logic [2:0] {
        S_IDLE,
        S_ACC,
        S_ABS,
        S_DIV,
        S_SIGN
    } t_state;

    // A scaled sample as an operand of the shared adder.
    typedef struct packed {
        logic        sub;
        logic        ext;
        logic [31:0] val;
    } t_scaled;

endpackage

`default_nettype wire

[hw/rtl/pbmf_scale.sv]
// ----------------------------------------------------------------------------
// PCM bytes to mono fixed: sample scaling
// Maps an assembled sample word of the given format onto Q0.31, as an
// operand and an add or subtract request for the accumulator.
// ----------------------------------------------------------------------------
`default_nettype none

module pbmf_scale
    import pbmf_pkg::*;
(
    input  wire logic [31:0] i_word,
    input  wire logic [2:0]  i_format,
    output t_scaled          o_scaled
);

    logic [7:0]  w_exp;
    logic [22:0] w_man;
    logic [30:0] w_sig;
    logic [7:0]  w_amt;
    logic [30:0] w_shifted;

    assign w_exp     = i_word[30:23];
    assign w_man     = i_word[22:0];
    assign w_sig     = {1'b1, w_man, 7'd0};
    assign w_amt     = 8'd126 - w_exp;
    assign w_shifted = w_sig >> w_amt[4:0];

    always_comb begin
        o_scaled = '0;
        case (i_format)
            FMT_U8: begin
                o_scaled.ext = 1'b1;
                o_scaled.val = {~i_word[7], i_word[6:0], 24'd0};
            end
            FMT_S16: begin
                o_scaled.ext = 1'b1;
                o_scaled.val = {i_word[15:0], 16'd0};
            end
            FMT_S24: begin
                o_scaled.ext = 1'b1;
                o_scaled.val = {i_word[23:0], 8'd0};
            end
            FMT_F32: begin
                o_scaled.ext = 1'b0;
                o_scaled.sub = i_word[31];
                if (w_exp == 8'hFF && w_man != 23'd0) begin
                    o_scaled.sub = 1'b0;
                    o_scaled.val = 32'd0;
                end else if (w_exp == 8'd0) begin
                    o_scaled.val = 32'd0;
                end else if (w_exp >= 8'd127) begin
                    o_scaled.val = i_word[31] ? 32'h8000_0000 : 32'h7FFF_FFFF;
                end else if (w_exp <= 8'd95) begin
                    o_scaled.val = 32'd0;
                end else begin
                    o_scaled.val = {1'b0, w_shifted};
                end
            end
            default: begin
                o_scaled.ext = 1'b1;
                o_scaled.val = i_word;
            end
        endcase
    end

endmodule

`default_nettype wire

[hw/rtl/pcm_bytes_to_mono_fixed.sv]
// ----------------------------------------------------------------------------
// PCM bytes to mono fixed: top level
// Assembles raw audio bytes into samples, scales them to Q0.31 and emits the
// channel mean of each frame, flagging the final frame of a block.
// ----------------------------------------------------------------------------
// A byte that does not finish a sample leaves the block idle. A byte that finishes
// a sample but not its frame is accepted, and its scaled sample is then added into
// the frame sum in the accumulate state. A byte that finishes a frame also runs the
// absolute value, the bit-serial division of the frame sum by the channel count,
// which runs one quotient bit per cycle on the same adder that accumulates the
// samples, and the sign fix, which waits until the output register is free.
// The input stalls for that whole time; a finished result waits in the
// output register while the next bytes are taken.
`default_nettype none

`include "pcm_bytes_to_mono_fixed_macros.svh"

module pcm_bytes_to_mono_fixed
    import pbmf_pkg::*;
#(
    parameter int MAX_CHANNELS = 8
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,

    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [3:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready,

    input  wire logic        i_valid,
    output logic             o_stall,
    input  wire logic [7:0]  i_data_byte,

    output logic             o_valid,
    input  wire logic        i_stall,
    output logic [31:0]      o_mono_sample,
    output logic             o_last_frame
);

    localparam int SUM_W = 32 + $clog2(MAX_CHANNELS);
    localparam int ADD_W = SUM_W + 1;
    localparam int CH_W  = $clog2(MAX_CHANNELS + 1);
    localparam int CI_W  = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
    localparam int CNT_W = $clog2(SUM_W + 1);

    logic [2:0]       r_format;
    logic             r_big_endian;
    logic [3:0]       r_channels;
    logic [23:0]      r_frames;

    t_state           r_state, n_state;
    logic [1:0]       r_byte_idx, n_byte_idx;
    logic [CI_W-1:0]  r_ch_idx, n_ch_idx;
    logic [31:0]      r_word, n_word;
    logic [SUM_W-1:0] r_sum, n_sum;
    logic [23:0]      r_frame_idx, n_frame_idx;
    logic [SUM_W-1:0] r_dvd, n_dvd;
    logic [CH_W-1:0]  r_rem, n_rem;
    logic             r_neg, n_neg;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic             r_out_valid, n_out_valid;
    logic [31:0]      r_mono, n_mono;
    logic             r_last, n_last;

    logic             w_cfg_wr;
    logic             w_in_acc;
    logic             w_out_free;
    logic [1:0]       w_nb_m1;
    logic [CH_W-1:0]  w_ch;
    logic [23:0]      w_fc;
    logic [31:0]      w_word_in;
    logic [CH_W:0]    w_rem_sh;
    logic             w_last;
    t_scaled          w_scaled;

    logic [ADD_W-1:0] w_add_a, w_add_b, w_add;
    logic             w_add_sub;

    pbmf_scale u_scale (
        .i_word   (r_word),
        .i_format (r_format),
        .o_scaled (w_scaled)
    );

    assign pready   = 1'b1;
    assign w_cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_format     <= FMT_S16;
            r_big_endian <= 1'b0;
            r_channels   <= 4'd2;
            r_frames     <= 24'd1;
        end else if (w_cfg_wr) begin
            case (paddr[3:2])
                REG_FORMAT:     r_format     <= pwdata[2:0];
                REG_BIG_ENDIAN: r_big_endian <= pwdata[0];
                REG_CHANNELS:   r_channels   <= pwdata[3:0];
                REG_FRAMES:     r_frames     <= pwdata[23:0];
                default:        r_format     <= r_format;
            endcase
        end
    end

    always_comb begin
        case (paddr[3:2])
            REG_FORMAT:     prdata = {29'd0, r_format};
            REG_BIG_ENDIAN: prdata = {31'd0, r_big_endian};
            REG_CHANNELS:   prdata = {28'd0, r_channels};
            REG_FRAMES:     prdata = {8'd0, r_frames};
            default:        prdata = 32'd0;
        endcase
    end

    always_comb begin
        case (r_format)
            FMT_U8:  w_nb_m1 = 2'd0;
            FMT_S16: w_nb_m1 = 2'd1;
            FMT_S24: w_nb_m1 = 2'd2;
            default: w_nb_m1 = 2'd3;
        endcase
        if (r_channels == 4'd0) begin
            w_ch = CH_W'(1);
        end else if (32'(r_channels) > MAX_CHANNELS) begin
            w_ch = CH_W'(MAX_CHANNELS);
        end else begin
            w_ch = CH_W'(r_channels);
        end
        w_fc = (r_frames == 24'd0) ? 24'd1 : r_frames;
    end

    assign o_stall    = (r_state != S_IDLE);
    assign w_in_acc   = i_valid && !o_stall;
    assign w_out_free = !r_out_valid || !i_stall;
    assign w_word_in  = r_big_endian ? {r_word[23:0], i_data_byte}
                                     : r_word | (32'(i_data_byte) << {r_byte_idx, 3'd0});
    assign w_rem_sh   = {r_rem, r_dvd[SUM_W-1]};
    assign w_last     = (25'(r_frame_idx) + 25'd1) >= {1'b0, w_fc};

    // Shared adder: accumulation, absolute value, division steps and sign fix.
    always_comb begin
        w_add_a   = '0;
        w_add_b   = '0;
        w_add_sub = 1'b1;
        case (r_state)
            S_ACC: begin
                w_add_a   = {r_sum[SUM_W-1], r_sum};
                w_add_b   = w_scaled.ext
                          ? {{(ADD_W-32){w_scaled.val[31]}}, w_scaled.val}
                          : {{(ADD_W-32){1'b0}}, w_scaled.val};
                w_add_sub = w_scaled.sub;
            end
            S_ABS: begin
                w_add_b = {r_sum[SUM_W-1], r_sum};
            end
            S_DIV: begin
                w_add_a = ADD_W'(w_rem_sh);
                w_add_b = ADD_W'(w_ch);
            end
            S_SIGN: begin
                w_add_b = {1'b0, r_dvd};
            end
            default: begin
                w_add_sub = 1'b1;
            end
        endcase
    end

    assign w_add = w_add_a + (w_add_sub ? ~w_add_b : w_add_b) + ADD_W'(w_add_sub);

    always_comb begin
        n_state     = r_state;
        n_byte_idx  = r_byte_idx;
        n_ch_idx    = r_ch_idx;
        n_word      = r_word;
        n_sum       = r_sum;
        n_frame_idx = r_frame_idx;
        n_dvd       = r_dvd;
        n_rem       = r_rem;
        n_neg       = r_neg;
        n_cnt       = r_cnt;
        n_out_valid = r_out_valid && i_stall;
        n_mono      = r_mono;
        n_last      = r_last;
        case (r_state)
            S_IDLE: begin
                if (w_in_acc) begin
                    n_word = w_word_in;
                    if (r_byte_idx < w_nb_m1) begin
                        n_byte_idx = r_byte_idx + 2'd1;
                    end else begin
                        n_byte_idx = 2'd0;
                        n_state    = S_ACC;
                    end
                end
            end
            S_ACC: begin
                n_sum  = w_add[SUM_W-1:0];
                n_word = 32'd0;
                if ((32'(r_ch_idx) + 32'd1) < 32'(w_ch)) begin
                    n_ch_idx = r_ch_idx + CI_W'(1);
                    n_state  = S_IDLE;
                end else begin
                    n_ch_idx = '0;
                    n_state  = S_ABS;
                end
            end
            S_ABS: begin
                n_neg   = r_sum[SUM_W-1];
                n_dvd   = r_sum[SUM_W-1] ? w_add[SUM_W-1:0] : r_sum;
                n_sum   = '0;
                n_rem   = '0;
                n_cnt   = CNT_W'(SUM_W);
                n_state = S_DIV;
            end
            S_DIV: begin
                n_rem = w_add[ADD_W-1] ? w_rem_sh[CH_W-1:0] : w_add[CH_W-1:0];
                n_dvd = {r_dvd[SUM_W-2:0], !w_add[ADD_W-1]};
                n_cnt = r_cnt - CNT_W'(1);
                if (r_cnt == CNT_W'(1)) begin
                    n_state = S_SIGN;
                end
            end
            S_SIGN: begin
                if (w_out_free) begin
                    n_out_valid = 1'b1;
                    n_mono      = r_neg ? w_add[31:0] : r_dvd[31:0];
                    n_last      = w_last;
                    n_frame_idx = w_last ? 24'd0 : r_frame_idx + 24'd1;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_byte_idx  <= 2'd0;
            r_ch_idx    <= '0;
            r_word      <= 32'd0;
            r_sum       <= '0;
            r_frame_idx <= 24'd0;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_byte_idx  <= n_byte_idx;
            r_ch_idx    <= n_ch_idx;
            r_word      <= n_word;
            r_sum       <= n_sum;
            r_frame_idx <= n_frame_idx;
            r_cnt       <= n_cnt;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_dvd  <= n_dvd;
        r_rem  <= n_rem;
        r_neg  <= n_neg;
        r_mono <= n_mono;
        r_last <= n_last;
    end

    assign o_valid       = r_out_valid;
    assign o_mono_sample = r_mono;
    assign o_last_frame  = r_last;

    `PBMF_ASSERT_NOW(a_rem_below_divisor, i_clk, i_rst_n, r_state == S_DIV, r_rem < w_ch)
    `PBMF_ASSERT_NOW(a_sum_clear_at_frame_start, i_clk, i_rst_n,
        r_state == S_IDLE && r_ch_idx == '0, r_sum == '0)
    `PBMF_ASSERT_NEXT(a_result_loaded, i_clk, i_rst_n,
        r_state == S_SIGN && w_out_free, o_valid && r_state == S_IDLE)
    `PBMF_ASSERT_NEXT(a_sample_goes_to_acc, i_clk, i_rst_n,
        w_in_acc && r_byte_idx >= w_nb_m1, r_state == S_ACC)

endmodule

`default_nettype wire

[tb/sv/pcm_bytes_to_mono_fixed_tb.sv]
// ----------------------------------------------------------------------------
// PCM bytes to mono fixed: testbench
// Streams raw audio bytes through the converter in every sample format and byte
// order and in a range of channel settings, predicts each frame mean and last
// flag locally, and checks every result while both sides stall at random.
// ----------------------------------------------------------------------------
module testbench;
    import pbmf_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int MAX_CHANNELS = 8;
    localparam int MAX_GAP = 6;
    localparam int QUIET_CYCLES = 64;
    localparam int RANDOM_BYTES = 1450;
    localparam int BURST_CYCLES = 300;
    localparam logic [2:0] FMT_UNUSED = 3'd7;
    localparam longint Q31_MAX = 64'sd2147483647;
    localparam longint Q31_MIN = -64'sd2147483648;

    typedef struct {
        logic [31:0] mono_sample;
        logic        last_frame;
    } t_frame_mean;

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [3:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;
    logic        i_valid;
    logic        o_stall;
    logic [7:0]  i_data_byte;
    logic        o_valid;
    logic        i_stall;
    logic [31:0] o_mono_sample;
    logic        o_last_frame;

    logic [2:0]  cfg_format = FMT_S16;
    logic        cfg_big_endian = 1'b0;
    logic [3:0]  cfg_channels = 4'd2;
    logic [23:0] cfg_frame_count = 24'd1;

    int unsigned byte_pos = 0;
    int unsigned chan_pos = 0;
    int unsigned frame_pos = 0;
    logic [31:0] sample_word = '0;
    longint      frame_sum = 0;

    t_frame_mean pending_means[$];
    int mismatches = 0;
    int bytes_accepted = 0;
    int tx_max_gap = MAX_GAP;
    int rx_max_hold = MAX_GAP;
    int stall_burst = 0;

    pcm_bytes_to_mono_fixed #(
        .MAX_CHANNELS(MAX_CHANNELS)
    ) dut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .psel(psel),
        .penable(penable),
        .pwrite(pwrite),
        .paddr(paddr),
        .pwdata(pwdata),
        .prdata(prdata),
        .pready(pready),
        .i_valid(i_valid),
        .o_stall(o_stall),
        .i_data_byte(i_data_byte),
        .o_valid(o_valid),
        .i_stall(i_stall),
        .o_mono_sample(o_mono_sample),
        .o_last_frame(o_last_frame)
    );

    always #5 i_clk = ~i_clk;

    function automatic int bytes_per_sample(input logic [2:0] fmt);
        case (fmt)
            FMT_U8:  return 1;
            FMT_S16: return 2;
            FMT_S24: return 3;
            default: return 4;
        endcase
    endfunction

    function automatic int active_channels();
        if (cfg_channels == 0) return 1;
        if (cfg_channels > MAX_CHANNELS) return MAX_CHANNELS;
        return int'(cfg_channels);
    endfunction

    function automatic longint float_to_q31(input logic [31:0] w);
        int     sh;
        longint sig;
        longint mag;
        if (w[30:23] == 8'hFF && w[22:0] != 0) return 0;
        if (w[30:23] == 8'h00) return 0;
        if (w[30:23] == 8'hFF) return w[31] ? Q31_MIN : Q31_MAX;
        sh = int'(w[30:23]) - 119;
        if (sh >= 8) return w[31] ? Q31_MIN : Q31_MAX;
        sig = longint'({1'b1, w[22:0]});
        if (sh >= 0) begin
            mag = sig << sh;
        end else if (-sh >= 24) begin
            mag = 0;
        end else begin
            mag = sig >> (-sh);
        end
        return w[31] ? -mag : mag;
    endfunction

    function automatic longint scale_to_q31(input logic [31:0] w);
        case (cfg_format)
            FMT_U8:  return (longint'(w[7:0]) - 128) * 64'sd16777216;
            FMT_S16: return longint'($signed(w[15:0])) * 64'sd65536;
            FMT_S24: return longint'($signed(w[23:0])) * 64'sd256;
            FMT_F32: return float_to_q31(w);
            default: return longint'($signed(w));
        endcase
    endfunction

    function automatic void absorb_byte(input logic [7:0] value);
        int unsigned nb;
        int unsigned ch;
        int unsigned fc;
        longint      mean;
        t_frame_mean result;
        nb = bytes_per_sample(cfg_format);
        ch = active_channels();
        fc = (cfg_frame_count == 0) ? 1 : cfg_frame_count;
        if (cfg_big_endian) begin
            sample_word = {sample_word[23:0], value};
        end else begin
            sample_word = sample_word | (32'(value) << (8 * (byte_pos & 3)));
        end
        if (byte_pos + 1 < nb) begin
            byte_pos++;
            return;
        end
        byte_pos = 0;
        frame_sum += scale_to_q31(sample_word);
        sample_word = '0;
        if (chan_pos + 1 < ch) begin
            chan_pos++;
            return;
        end
        chan_pos = 0;
        mean = frame_sum / longint'(ch);
        frame_sum = 0;
        result.mono_sample = mean[31:0];
        result.last_frame = (frame_pos + 1 >= fc);
        frame_pos = result.last_frame ? 0 : frame_pos + 1;
        pending_means.push_back(result);
    endfunction

    function automatic logic [31:0] random_sample(input logic [2:0] fmt);
        logic [31:0] top;
        logic [7:0]  ex;
        top = 32'h1 << (8 * bytes_per_sample(fmt) - 1);
        if (fmt == FMT_F32) begin
            case ($urandom_range(0, 9))
                0:       ex = 8'h00;
                1:       ex = 8'hFF;
                2:       ex = 8'(126 + $urandom_range(0, 10));
                default: ex = 8'(95 + $urandom_range(0, 31));
            endcase
            return {1'($urandom), ex, ($urandom_range(0, 3) == 0) ? 23'd0 : 23'($urandom)};
        end
        case ($urandom_range(0, 7))
            0:       return top;
            1:       return top - 1;
            2:       return '0;
            3:       return '1;
            default: return $urandom;
        endcase
    endfunction

    task automatic send_byte(input logic [7:0] value);
        int gap;
        gap = (tx_max_gap == 0) ? 0 : $urandom_range(0, tx_max_gap);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_data_byte <= value;
        do @(posedge i_clk); while (o_stall);
        absorb_byte(value);
        bytes_accepted++;
    endtask

    task automatic send_sample(input logic [31:0] word);
        int nb;
        int k;
        nb = bytes_per_sample(cfg_format);
        for (k = 0; k < nb; k++) begin
            send_byte(cfg_big_endian ? word[8 * (nb - 1 - k) +: 8] : word[8 * k +: 8]);
        end
    endtask

    task automatic wait_quiet();
        i_valid <= 1'b0;
        while (pending_means.size() != 0) @(posedge i_clk);
        repeat (QUIET_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_register(input logic [1:0] index, input logic [31:0] value);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {index, 2'b00};
        pwdata <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel <= 1'b0;
        penable <= 1'b0;
        case (index)
            REG_FORMAT:     cfg_format = value[2:0];
            REG_BIG_ENDIAN: cfg_big_endian = value[0];
            REG_CHANNELS:   cfg_channels = value[3:0];
            REG_FRAMES:     cfg_frame_count = value[23:0];
            default:        cfg_format = cfg_format;
        endcase
        @(posedge i_clk);
    endtask

    task automatic check_register(input logic [1:0] index, input logic [31:0] want);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b0;
        paddr <= {index, 2'b00};
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        if (prdata !== want) begin
            $error("register %0d: expected %0h, got %0h", index, want, prdata);
            mismatches++;
        end
        psel <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic configure(input logic [2:0] fmt, input logic big, input logic [3:0] chans,
                             input logic [23:0] frames);
        wait_quiet();
        write_register(REG_FORMAT, 32'(fmt));
        write_register(REG_BIG_ENDIAN, 32'(big));
        write_register(REG_CHANNELS, 32'(chans));
        write_register(REG_FRAMES, 32'(frames));
    endtask

    task automatic test_reset_defaults();
        check_register(REG_FORMAT, 32'(FMT_S16));
        check_register(REG_BIG_ENDIAN, 32'd0);
        check_register(REG_CHANNELS, 32'd2);
        check_register(REG_FRAMES, 32'd1);
        send_sample(32'h0000_8000);
        send_sample(32'h0000_7FFF);
    endtask

    task automatic test_integer_formats();
        configure(FMT_U8, 1'b0, 4'd1, 24'd1);
        send_byte(8'h00);
        send_byte(8'hFF);
        configure(FMT_S24, 1'b1, 4'd1, 24'd1);
        send_sample(32'h0080_0000);
        configure(FMT_S32, 1'b1, 4'd1, 24'd1);
        send_sample(32'h7FFF_FFFF);
        check_register(REG_FORMAT, 32'(FMT_S32));
        check_register(REG_BIG_ENDIAN, 32'd1);
    endtask

    task automatic test_float_conversion();
        configure(FMT_F32, 1'b0, 4'd1, 24'd1);
        send_sample(32'h3F80_0000);
        send_sample(32'h7FC0_0000);
        send_sample(32'hFF80_0000);
    endtask

    task automatic test_config_limits();
        int i;
        configure(FMT_UNUSED, 1'b0, 4'd0, 24'd0);
        send_sample(32'h8000_0000);
        configure(FMT_U8, 1'b0, 4'd15, 24'd0);
        check_register(REG_CHANNELS, 32'd15);
        check_register(REG_FRAMES, 32'd0);
        for (i = 0; i < MAX_CHANNELS; i++) begin
            send_byte(i[0] ? 8'h00 : 8'hFF);
        end
    endtask

    task automatic test_reconfigure_mid_frame();
        configure(FMT_S16, 1'b0, 4'd2, 24'd4);
        repeat (4) send_sample(random_sample(cfg_format));
        send_sample(random_sample(cfg_format));
        send_byte(8'($urandom));
        configure(FMT_U8, 1'b0, 4'd1, 24'd2);
        repeat (3) send_byte(8'($urandom));
    endtask

    task automatic test_output_backpressure();
        configure(FMT_U8, 1'b0, 4'd1, 24'hFF_FFFF);
        tx_max_gap = 0;
        rx_max_hold = 0;
        stall_burst = BURST_CYCLES;
        repeat (40) send_byte(8'($urandom));
        tx_max_gap = MAX_GAP;
        rx_max_hold = MAX_GAP;
    endtask

    task automatic test_random_stream();
        int          target;
        logic [2:0]  fmt;
        logic [3:0]  chans;
        logic [23:0] frames;
        target = bytes_accepted + RANDOM_BYTES;
        while (bytes_accepted < target) begin
            fmt = ($urandom_range(0, 7) == 0) ? 3'($urandom_range(5, 7))
                                              : 3'($urandom_range(0, 4));
            chans = ($urandom_range(0, 7) == 0) ? 4'($urandom_range(0, 15))
                                                : 4'($urandom_range(1, MAX_CHANNELS));
            case ($urandom_range(0, 7))
                0:       frames = 24'd0;
                1:       frames = 24'hFF_FFFF;
                default: frames = 24'($urandom_range(1, 6));
            endcase
            configure(fmt, 1'($urandom), chans, frames);
            tx_max_gap = $urandom_range(0, 1) ? MAX_GAP : 0;
            rx_max_hold = $urandom_range(0, 1) ? MAX_GAP : 0;
            repeat ($urandom_range(3, 12)) begin
                repeat (active_channels()) send_sample(random_sample(cfg_format));
            end
            if ($urandom_range(0, 5) == 0) begin
                repeat ($urandom_range(1, 5)) send_byte(8'($urandom));
            end
        end
    endtask

    initial begin : result_sink
        int hold;
        i_stall <= 1'b0;
        wait (i_rst_n === 1'b1);
        forever begin
            hold = (rx_max_hold == 0) ? 0 : $urandom_range(0, rx_max_hold);
            if (stall_burst > 0) begin
                hold = stall_burst;
                stall_burst = 0;
            end
            if (hold > 0) begin
                i_stall <= 1'b1;
                repeat (hold) @(posedge i_clk);
            end
            i_stall <= 1'b0;
            do @(posedge i_clk); while (!o_valid);
        end
    end

    always @(posedge i_clk) begin : result_check
        t_frame_mean want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (pending_means.size() == 0) begin
                $error("result with no frame pending: mono_sample %0d, last_frame %0b",
                       $signed(o_mono_sample), o_last_frame);
                mismatches++;
            end else begin
                want = pending_means.pop_front();
                if (o_mono_sample !== want.mono_sample) begin
                    $error("mono_sample: expected %0d, got %0d",
                           $signed(want.mono_sample), $signed(o_mono_sample));
                    mismatches++;
                end
                if (o_last_frame !== want.last_frame) begin
                    $error("last_frame: expected %0b, got %0b", want.last_frame, o_last_frame);
                    mismatches++;
                end
            end
        end
    end

    initial begin
        #10_000_000;
        $display("pcm_bytes_to_mono_fixed: mismatch");
        $finish;
    end

    initial begin
        i_rst_n <= 1'b0;
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        paddr <= '0;
        pwdata <= '0;
        i_valid <= 1'b0;
        i_data_byte <= '0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_reset_defaults();
        test_integer_formats();
        test_float_conversion();
        test_config_limits();
        test_reconfigure_mid_frame();
        test_output_backpressure();
        test_random_stream();
        wait_quiet();
        if (mismatches == 0) begin
            $display("pcm_bytes_to_mono_fixed: match");
        end else begin
            $display("pcm_bytes_to_mono_fixed: mismatch");
        end
        $finish;
    end

endmodule
